// File: src/swm_pkg.sv
`timescale 1ns / 1ps
package swm_pkg;

    // Configuration register file
    localparam int CFG_WIDTH  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic clear;  // drop every cell
        logic age;    // advance every age by one
        logic shift;  // take the right neighbor's contents
        logic step;   // pop smaller back cells and append the sample
    } t_ctl;

endpackage

// File: src/swm_stream_if.sv
`timescale 1ns / 1ps
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;
    logic                           last;

    modport source (output valid, output sample, output start_req, output last, input ready);
    modport sink (input valid, input sample, input start_req, input last, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           final_res;

    modport source (output valid, output window_max, output final_res, input ready);
    modport sink (input valid, input window_max, input final_res, output ready);
endinterface

// File: src/swm_cell.sv
`timescale 1ns / 1ps
module swm_cell #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  swm_pkg::t_ctl                          i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_smp,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_nxt_val,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]        i_nxt_age,
    input  logic                                   i_nxt_vld,
    input  logic                                   i_prev_keep,
    output logic signed [SAMPLE_WIDTH-1:0]         o_val,
    output logic [$clog2(WINDOW_MAX+1)-1:0]        o_age,
    output logic                                   o_vld,
    output logic                                   o_keep
);
    import swm_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX+1);

    logic signed [SAMPLE_WIDTH-1:0] r_val, n_val, src_val;
    logic [AW-1:0]                  r_age, n_age, src_age;
    logic                           r_vld, n_vld, src_vld;

    // Contents this cell holds after an optional shift from the right
    assign src_val = i_ctl.shift ? i_nxt_val : r_val;
    assign src_age = i_ctl.shift ? i_nxt_age : r_age;
    assign src_vld = i_ctl.shift ? i_nxt_vld : r_vld;

    // Survives the pop: valid and not strictly smaller than the sample
    assign o_keep = src_vld && !(src_val < i_smp);

    always_comb begin
        n_val = r_val;
        n_age = r_age;
        n_vld = r_vld;
        if (i_ctl.age && (r_age < AW'(WINDOW_MAX))) begin
            n_age = r_age + AW'(1);
        end
        if (i_ctl.step) begin
            if (o_keep) begin
                n_val = src_val;
                n_age = src_age;
                n_vld = 1'b1;
            end else if (i_prev_keep) begin
                n_val = i_smp;
                n_age = '0;
                n_vld = 1'b1;
            end else begin
                n_vld = 1'b0;
            end
        end else if (i_ctl.shift) begin
            n_val = src_val;
            n_age = src_age;
            n_vld = src_vld;
        end
        if (i_ctl.clear) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

    assign o_val = r_val;
    assign o_age = r_age;
    assign o_vld = r_vld;

endmodule

// File: src/sliding_window_maximum.sv
`timescale 1ns / 1ps
// Sliding-window maximum over a stream of signed samples. From the
// window_size-th sample of a stream on, each sample yields one result
// transaction carrying the maximum of the last window_size samples, with
// final_res copying the sample's last flag. start_req clears the window
// before its sample is taken; a last sample clears it afterwards, and a
// stream shorter than the window yields nothing. window_size is written
// over the APB port at address 0 (0 acts as 1, values above WINDOW_MAX act
// as WINDOW_MAX) and takes effect from the next sample. Each sample is
// accepted in the idle state and then processed in the cell chain; no new
// sample is taken until the last one is through. Each front cell beyond
// the first that expires at once (only after window_size shrinks) adds a
// shift step first, since the chain moves its contents by one cell per
// cycle. Processing waits while a previous result is still held and not
// taken. No clearing pass follows reset: cells carry their own valid flags.
module sliding_window_maximum #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    swm_in_if.sink                               i_smp,
    swm_out_if.source                            o_res,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import swm_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX+1);
    localparam int CW = (AW > CFG_WIDTH) ? AW : CFG_WIDTH;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CFG_WIDTH-1:0] r_wsize;
    logic [CW-1:0]        wsize_ext;
    logic [AW-1:0]        win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WINDOW_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE)) begin
            r_wsize <= pwdata[CFG_WIDTH-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? APB_DATA_W'(r_wsize) : '0;

    // Clamp the window into 1..WINDOW_MAX
    assign wsize_ext = CW'(r_wsize);
    assign win = (wsize_ext == '0)              ? AW'(1) :
                 (wsize_ext > CW'(WINDOW_MAX))  ? AW'(WINDOW_MAX) :
                                                  AW'(wsize_ext);

    // ---------------------------------------------------------------
    // Cell chain: cell 0 is the front (oldest, largest candidate).
    // Entry WINDOW_MAX is a permanently empty pad past the back.
    // ---------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] c_val  [0:WINDOW_MAX];
    logic [AW-1:0]                  c_age  [0:WINDOW_MAX];
    logic                           c_vld  [0:WINDOW_MAX];
    logic                           c_keep [0:WINDOW_MAX-1];
    t_ctl                           ctl;

    logic signed [SAMPLE_WIDTH-1:0] r_smp;
    logic                           r_last;

    assign c_val[WINDOW_MAX] = '0;
    assign c_age[WINDOW_MAX] = '0;
    assign c_vld[WINDOW_MAX] = 1'b0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic prev_keep;
        if (g == 0) begin : g_front
            assign prev_keep = 1'b1;
        end else begin : g_rest
            assign prev_keep = c_keep[g-1];
        end
        swm_cell #(
            .WINDOW_MAX   (WINDOW_MAX),
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_smp       (r_smp),
            .i_nxt_val   (c_val[g+1]),
            .i_nxt_age   (c_age[g+1]),
            .i_nxt_vld   (c_vld[g+1]),
            .i_prev_keep (prev_keep),
            .o_val       (c_val[g]),
            .o_age       (c_age[g]),
            .o_vld       (c_vld[g]),
            .o_keep      (c_keep[g])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    logic   [AW-1:0] r_seen, seen_inc;
    logic   in_fire, out_free, exp0, exp1, multi_exp, produce;
    logic   r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_omax, front_val;
    logic   r_ofinal;

    assign in_fire  = i_smp.valid && i_smp.ready;
    assign out_free = !r_ovalid || o_res.ready;

    // Ages were advanced when the sample was accepted
    assign exp0      = c_vld[0] && (c_age[0] >= win);
    assign exp1      = c_vld[1] && (c_age[1] >= win);
    assign multi_exp = exp0 && exp1;

    assign seen_inc = (r_seen < AW'(WINDOW_MAX)) ? r_seen + AW'(1) : r_seen;
    assign produce  = (seen_inc >= win);

    // Front after this step: the surviving front cell, else the new sample
    assign front_val = c_keep[0] ? (exp0 ? c_val[1] : c_val[0]) : r_smp;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!multi_exp && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl         = '0;
        i_smp.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Take no transaction while reset is held
                i_smp.ready = i_rst_n;
                if (in_fire) begin
                    ctl.age   = 1'b1;
                    ctl.clear = i_smp.start_req;
                end
            end
            ST_RUN: begin
                if (multi_exp) begin
                    // Retire one expired front cell and hold the sample
                    ctl.shift = 1'b1;
                end else if (out_free) begin
                    ctl.shift = exp0;
                    // A last sample empties the window as its result is registered
                    ctl.step  = !r_last;
                    ctl.clear = r_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && i_smp.start_req) begin
                r_seen <= '0;
            end else if (r_state == ST_RUN && !multi_exp && out_free) begin
                r_seen <= r_last ? '0 : seen_inc;
            end
            if (r_state == ST_RUN && !multi_exp && out_free) begin
                r_ovalid <= produce;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Hold the accepted sample and the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_smp  <= i_smp.sample;
            r_last <= i_smp.last;
        end
        if (r_state == ST_RUN && !multi_exp && out_free) begin
            r_omax   <= front_val;
            r_ofinal <= r_last;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.window_max = r_omax;
    assign o_res.final_res  = r_ofinal;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import swm_pkg::*;

    localparam int SW          = 16;
    localparam int DEPTH       = 64;      // WINDOW_MAX of the block
    localparam int RANDOM_ITEMS = 400;
    localparam int SETTLE      = 100;     // covers the longest multi-cell expiry
    localparam int HOLD_OFF    = 300;     // long receiver stall for the fill test
    localparam int CYCLE_LIMIT = 400000;

    // Sample shapes for the random streams
    typedef enum int {
        SHAPE_NOISE,    // uniform over the full 16-bit range
        SHAPE_CLUSTER,  // tiny range, lots of equal values
        SHAPE_FALLING,  // strictly falling, grows the candidate queue
        SHAPE_RISING,   // strictly rising, pops the whole queue each time
        SHAPE_EXTREME   // only the corner values
    } t_shape;

    typedef struct {
        logic signed [SW-1:0] window_max;
        logic                 final_res;
    } t_window_result;

    // Window-maximum predictor plus the queue of results still owed by the block
    class swm_scoreboard;
        logic signed [SW-1:0] cand_val[$];
        int                   cand_age[$];
        int                   seen_count;
        logic [CFG_WIDTH-1:0] win_reg;
        t_window_result       owed_q[$];
        int                   errors;

        function void reset_model();
            cand_val.delete();
            cand_age.delete();
            seen_count = 0;
            win_reg    = WINDOW_SIZE_RESET;
            owed_q.delete();
            errors     = 0;
        endfunction

        function void set_window(logic [CFG_WIDTH-1:0] w);
            win_reg = w;
        endfunction

        function int eff_window();
            int w;
            w = int'(win_reg);
            if (w == 0) w = 1;
            if (w > DEPTH) w = DEPTH;
            return w;
        endfunction

        function void clear_window();
            cand_val.delete();
            cand_age.delete();
            seen_count = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advance the candidate queue by one accepted sample
        function void note_sample(logic signed [SW-1:0] smp, logic st, logic lst);
            int             w;
            t_window_result r;
            w = eff_window();
            if (st) clear_window();
            foreach (cand_age[i])
                if (cand_age[i] < DEPTH) cand_age[i]++;
            // Drop expired candidates at the front
            while (cand_age.size() > 0 && cand_age[0] >= w) begin
                cand_age.delete(0);
                cand_val.delete(0);
            end
            // Drop smaller candidates at the back
            while (cand_val.size() > 0 && cand_val[cand_val.size()-1] < smp) begin
                cand_age.delete(cand_age.size() - 1);
                cand_val.delete(cand_val.size() - 1);
            end
            if (cand_val.size() < DEPTH) begin
                cand_val.insert(cand_val.size(), smp);
                cand_age.insert(cand_age.size(), 0);
            end
            if (seen_count < DEPTH) seen_count++;
            if (seen_count >= w) begin
                r.window_max = cand_val[0];
                r.final_res  = lst;
                owed_q.insert(owed_q.size(), r);
            end
            if (lst) clear_window();
        endfunction

        function void check_result(logic signed [SW-1:0] wm, logic fr);
            t_window_result e;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result window_max=%0d final_res=%0b", $time, wm, fr);
                errors++;
                return;
            end
            e = owed_q[0];
            owed_q.delete(0);
            if (wm !== e.window_max) begin
                $display("%0t: window_max expected %0d got %0d", $time, e.window_max, wm);
                errors++;
            end
            if (fr !== e.final_res) begin
                $display("%0t: final_res expected %0b got %0b", $time, e.final_res, fr);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    swm_in_if  #(.SAMPLE_WIDTH(SW)) smp_if ();
    swm_out_if #(.SAMPLE_WIDTH(SW)) res_if ();

    swm_scoreboard sb = new;

    bit snd_fast;       // sender offers back to back while set
    bit rcv_fast;       // receiver does not stall while set, unless a hold-off is requested
    bit hold_off_req;   // ask the receiver for one long stall
    int items_sent;
    int cycles;

    sliding_window_maximum #(
        .WINDOW_MAX  (DEPTH),
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_smp  (smp_if),
        .o_res  (res_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bound the run; a hang anywhere ends here
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Feed every accepted sample transaction to the predictor
    always @(posedge clk) begin
        if (rst_n === 1'b1 && smp_if.valid === 1'b1 && smp_if.ready === 1'b1)
            sb.note_sample(smp_if.sample, smp_if.start_req, smp_if.last);
    end

    // Compare every accepted result transaction with the oldest owed one
    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(res_if.window_max, res_if.final_res);
    end

    // Receiver: draw a stall before each result, hold ready until a transaction.
    // Flip between stalling and streaming now and then so both kinds of stretch occur.
    initial begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rcv_fast = !rcv_fast;
            stall = rcv_fast ? 0 : $urandom_range(0, 19);
            if (hold_off_req) begin
                stall        = HOLD_OFF;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
        end
    end

    // Offer one sample; return at the edge that accepts it, with valid still high
    task automatic send_sample(input logic signed [SW-1:0] smp, input logic st, input logic lst);
        int gap;
        gap = snd_fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.sample    <= smp;
        smp_if.start_req <= st;
        smp_if.last      <= lst;
        do @(posedge clk); while (smp_if.ready !== 1'b1);
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the chain settle
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Read the window register back and compare it with the predictor's copy
    task automatic check_window_reg();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CFG_WIDTH-1:0] !== sb.win_reg) begin
            $display("%0t: window_size readback expected %0d got %0d",
                     $time, sb.win_reg, prdata[CFG_WIDTH-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Only call while idle: nothing owed, chain settled
    task automatic apply_window(input logic [CFG_WIDTH-1:0] w);
        apb_write(ADDR_WINDOW_SIZE, {{(APB_DATA_W-CFG_WIDTH){1'b0}}, w});
        sb.set_window(w);
        check_window_reg();
    endtask

    function automatic logic signed [SW-1:0] pick_sample(t_shape shape, int idx, int base);
        int v;
        case (shape)
            SHAPE_NOISE:   v = $urandom;
            SHAPE_CLUSTER: v = $urandom_range(0, 6) - 3;
            SHAPE_FALLING: v = base - idx;
            SHAPE_RISING:  v = base + idx;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[SW-1:0];
    endfunction

    // Mostly small windows; the clamped values and the full depth now and then
    function automatic logic [CFG_WIDTH-1:0] pick_window();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return CFG_WIDTH'($urandom_range(65, 126));
            4, 5, 6, 7: return CFG_WIDTH'($urandom_range(9, 40));
            default: return CFG_WIDTH'($urandom_range(1, 8));
        endcase
    endfunction

    // One stream with random content; a rare stray start or last mixes in noise
    task automatic random_stream(input int len, input bit st, input bit lst);
        t_shape shape;
        int     base;
        logic   s;
        logic   l;
        shape = t_shape'($urandom_range(0, 4));
        base  = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++) begin
            s = (st && i == 0) || ($urandom_range(0, 99) == 0);
            l = (lst && i == len - 1) || ($urandom_range(0, 99) == 0);
            send_sample(pick_sample(shape, i, base), s, l);
        end
    endtask

    initial begin : main
        int w;
        int len;
        int r;
        int nstreams;
        bit st;

        // Drive every input to a known value and hold reset
        rst_n            <= 1'b0;
        smp_if.valid     <= 1'b0;
        smp_if.sample    <= '0;
        smp_if.start_req <= 1'b0;
        smp_if.last      <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        sb.reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of one straight out of reset: every sample is its own maximum
        check_window_reg();
        snd_fast = 1'b0;
        send_sample(16'sh7FFF, 1'b1, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sh0000, 1'b0, 1'b0);
        send_sample(16'shFFFF, 1'b0, 1'b1);
        drain();

        // Window of three: equal values, a restart mid-stream, a short stream,
        // and a stream that begins after a last without start_req
        apply_window(7'd3);
        send_sample(16'sd5, 1'b1, 1'b0);
        send_sample(16'sd5, 1'b0, 1'b0);
        send_sample(16'sd7, 1'b0, 1'b0);
        send_sample(16'sh8000, 1'b0, 1'b0);
        send_sample(16'sd7, 1'b0, 1'b1);
        send_sample(16'sd1, 1'b0, 1'b0);
        send_sample(16'sd9, 1'b1, 1'b0);
        send_sample(16'sd8, 1'b0, 1'b1);
        drain();

        // Zero acts as a window of one
        apply_window(7'd0);
        send_sample(-16'sd5, 1'b1, 1'b0);
        send_sample(16'sd6, 1'b0, 1'b1);
        drain();

        // Oversized window clamps to full depth; two samples give nothing
        apply_window(7'd127);
        send_sample(16'sd100, 1'b1, 1'b0);
        send_sample(16'sd200, 1'b0, 1'b1);
        drain();

        // Shrink the window mid-stream so several front cells expire at once
        apply_window(7'd6);
        for (int i = 0; i < 7; i++) send_sample(16'(10 - i), i == 0, 1'b0);
        drain();
        apply_window(7'd2);
        send_sample(16'sd3, 1'b0, 1'b1);
        drain();

        // Fill test: receiver holds off while samples keep coming back to back
        apply_window(7'd4);
        snd_fast     = 1'b1;
        hold_off_req = 1'b1;
        random_stream(40, 1'b1, 1'b1);
        drain();

        // Random phases: new window, a few streams, then wait for every result
        while (items_sent < RANDOM_ITEMS) begin
            apply_window(pick_window());
            w        = sb.eff_window();
            snd_fast = ($urandom_range(0, 3) == 0);
            nstreams = (w > 16) ? 1 : $urandom_range(1, 3);
            for (int k = 0; k < nstreams; k++) begin
                st = (k == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
                r  = $urandom_range(0, 9);
                if (r < 7)
                    random_stream(w + $urandom_range(0, 12), st, 1'b1);
                else if (r < 9)
                    random_stream($urandom_range(1, w), st, 1'b1);
                else
                    // leave the stream open so the next window applies mid-stream
                    random_stream($urandom_range(1, 8), st, 1'b0);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
src/swm_pkg.sv
src/swm_stream_if.sv
src/swm_cell.sv
src/sliding_window_maximum.sv
tb/tb.sv
